// File: rtl/core/kct_pkg.sv
// Package with the constants, codes and transfer types of the keyed count table.
`timescale 1ns / 1ps
`default_nettype none

package kct_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);
    localparam int LIM_W       = 6;
    localparam int CMP_W       = (OCC_W > LIM_W) ? OCC_W : LIM_W;
    localparam int KEY_W       = 32;
    localparam int CNT_W       = 32;
    localparam int AMT_W       = 16;
    localparam int ENTRY_W     = KEY_W + CNT_W;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam logic [LIM_W-1:0] SLOT_LIMIT_RESET = LIM_W'(24);
    localparam logic [CNT_W-1:0] COUNT_MAX        = '1;

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    localparam logic [ADDR_W-1:0] REG_SLOT_LIMIT = ADDR_W'(0);

    typedef struct packed {
        logic [1:0]       func;
        logic [KEY_W-1:0] item_key;
        logic [AMT_W-1:0] amount;
    } t_cmd;

    typedef struct packed {
        logic             accepted;
        logic [CNT_W-1:0] item_count;
        logic [5:0]       used_entries;
        logic             has_space;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/core/kct_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module kct_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                             i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/core/keyed_count_table.sv
// Top level of the keyed count table: sequencer, shared adder and compare, entry RAM.
//
//   Channel   Ports                                  Transfer when
//   command   start, busy, i_cmd                     start high and busy low
//   result    o_done, o_result                       o_done high (one cycle)
//   config    psel, penable, pwrite, paddr, pwdata,  psel, penable, pwrite, pready
//             prdata, pready
//
// A command scans the stored entries one at a time through the single RAM read port,
// reading and then comparing each, until the key matches or the entries run out. A remove
// that deletes an entry then moves each later entry down through the same port.
// Reset clears the entry count and returns the slot limit to 24; the RAM needs no clearing.
// The result is shown for one cycle and the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none

module keyed_count_table (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire kct_pkg::t_cmd                i_cmd,
    output logic                              o_done,
    output kct_pkg::t_result                  o_result,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [kct_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [kct_pkg::DATA_W-1:0]   pwdata,
    output logic      [kct_pkg::DATA_W-1:0]   prdata,
    output logic                              pready
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD   = 7'b0000010,
        S_CMP  = 7'b0000100,
        S_EXEC = 7'b0001000,
        S_SRD  = 7'b0010000,
        S_SWR  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    localparam int NXT_W = kct_pkg::OCC_W + 1;

    t_state                         r_state, n_state;
    logic [kct_pkg::LIM_W-1:0]      r_limit;
    logic [kct_pkg::OCC_W-1:0]      r_occ, n_occ;
    logic [kct_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic                           r_found, n_found;
    logic [kct_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    logic                           r_acc, n_acc;
    logic [1:0]                     r_func;
    logic [kct_pkg::KEY_W-1:0]      r_key;
    logic [kct_pkg::AMT_W-1:0]      r_amt;

    logic                           ram_we;
    logic [kct_pkg::IDX_W-1:0]      ram_waddr;
    logic [kct_pkg::ENTRY_W-1:0]    ram_wdata;
    logic [kct_pkg::IDX_W-1:0]      ram_raddr;
    logic [kct_pkg::ENTRY_W-1:0]    ram_rdata;

    logic [kct_pkg::CMP_W-1:0]      lim_ext;
    logic [kct_pkg::CMP_W-1:0]      eff_lim;
    logic                           has_space;
    logic [NXT_W-1:0]               idx_p1;
    logic [NXT_W-1:0]               idx_p2;
    logic [NXT_W-1:0]               occ_ext;
    logic                           is_sub;
    logic [kct_pkg::CNT_W:0]        alu_b;
    logic [kct_pkg::CNT_W:0]        alu_sum;
    logic                           cfg_wr;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = kct_pkg::DATA_W'(r_limit);

    assign lim_ext   = kct_pkg::CMP_W'(r_limit);
    assign eff_lim   = (lim_ext > kct_pkg::CMP_W'(kct_pkg::MAX_ENTRIES))
                     ? kct_pkg::CMP_W'(kct_pkg::MAX_ENTRIES) : lim_ext;
    assign has_space = kct_pkg::CMP_W'(r_occ) < eff_lim;

    assign idx_p1  = NXT_W'(r_idx) + NXT_W'(1);
    assign idx_p2  = NXT_W'(r_idx) + NXT_W'(2);
    assign occ_ext = NXT_W'(r_occ);

    assign is_sub  = (r_func == kct_pkg::FUNC_REMOVE);
    assign alu_b   = is_sub ? ~(kct_pkg::CNT_W + 1)'(r_amt) : (kct_pkg::CNT_W + 1)'(r_amt);
    assign alu_sum = {1'b0, r_cnt} + alu_b + (kct_pkg::CNT_W + 1)'(is_sub);

    assign ram_raddr = (r_state == S_SRD) ? idx_p1[kct_pkg::IDX_W-1:0] : r_idx;

    kct_ram #(
        .WIDTH (kct_pkg::ENTRY_W),
        .DEPTH (kct_pkg::MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_occ     = r_occ;
        n_idx     = r_idx;
        n_found   = r_found;
        n_cnt     = r_cnt;
        n_acc     = r_acc;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = {r_key, r_cnt};
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_cnt   = '0;
                    n_acc   = 1'b0;
                    n_state = (r_occ == '0) ? S_EXEC : S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (ram_rdata[kct_pkg::ENTRY_W-1:kct_pkg::CNT_W] == r_key) begin
                    n_found = 1'b1;
                    n_cnt   = ram_rdata[kct_pkg::CNT_W-1:0];
                    n_state = S_EXEC;
                end else if (idx_p1 >= occ_ext) begin
                    n_state = S_EXEC;
                end else begin
                    n_idx   = idx_p1[kct_pkg::IDX_W-1:0];
                    n_state = S_RD;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_func)
                    kct_pkg::FUNC_ADD: begin
                        if (r_amt != '0) begin
                            if (r_found) begin
                                n_cnt     = alu_sum[kct_pkg::CNT_W] ? kct_pkg::COUNT_MAX
                                                                    : alu_sum[kct_pkg::CNT_W-1:0];
                                n_acc     = 1'b1;
                                ram_we    = 1'b1;
                                ram_wdata = {r_key, n_cnt};
                            end else if (has_space) begin
                                n_cnt     = kct_pkg::CNT_W'(r_amt);
                                n_acc     = 1'b1;
                                n_occ     = r_occ + kct_pkg::OCC_W'(1);
                                ram_we    = 1'b1;
                                ram_waddr = r_occ[kct_pkg::IDX_W-1:0];
                                ram_wdata = {r_key, n_cnt};
                            end
                        end
                    end
                    kct_pkg::FUNC_REMOVE: begin
                        if (r_amt != '0 && r_found) begin
                            n_acc = 1'b1;
                            if (alu_sum[kct_pkg::CNT_W]
                                    || alu_sum[kct_pkg::CNT_W-1:0] == '0) begin
                                n_cnt = '0;
                                if (idx_p1 < occ_ext) begin
                                    n_state = S_SRD;
                                end else begin
                                    n_occ = r_occ - kct_pkg::OCC_W'(1);
                                end
                            end else begin
                                n_cnt     = alu_sum[kct_pkg::CNT_W-1:0];
                                ram_we    = 1'b1;
                                ram_wdata = {r_key, n_cnt};
                            end
                        end
                    end
                    kct_pkg::FUNC_QUERY: begin
                        n_acc = r_found;
                    end
                    default: begin
                        n_cnt = '0;
                    end
                endcase
            end
            S_SRD: begin
                n_state = S_SWR;
            end
            S_SWR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                if (idx_p2 < occ_ext) begin
                    n_idx   = idx_p1[kct_pkg::IDX_W-1:0];
                    n_state = S_SRD;
                end else begin
                    n_occ   = r_occ - kct_pkg::OCC_W'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_occ   <= '0;
            r_limit <= kct_pkg::SLOT_LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (cfg_wr && paddr[kct_pkg::ADDR_W-1:2]
                    == kct_pkg::REG_SLOT_LIMIT[kct_pkg::ADDR_W-1:2]) begin
                r_limit <= pwdata[kct_pkg::LIM_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_found <= n_found;
        r_cnt   <= n_cnt;
        r_acc   <= n_acc;
        if (r_state == S_IDLE && start) begin
            r_func <= i_cmd.func;
            r_key  <= i_cmd.item_key;
            r_amt  <= i_cmd.amount;
        end
    end

    assign busy                  = (r_state != S_IDLE);
    assign o_done                = (r_state == S_DONE);
    assign o_result.accepted     = r_acc;
    assign o_result.item_count   = r_cnt;
    assign o_result.used_entries = 6'(r_occ);
    assign o_result.has_space    = has_space;

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench of the keyed count table: directed rows and random phases.
`timescale 1ns / 1ps

module testbench;

    import kct_pkg::*;

    localparam logic [1:0] FUNC_NONE   = 2'd3;
    localparam int         CYCLE_LIMIT = 2000000;
    localparam int         POOL_N      = 40;
    localparam int         N_PHASES    = 6;
    localparam int         TAIL_CYCLES = 140;

    localparam int PHASE_LIMIT [N_PHASES] = '{32, 0, 63, 5, 1, 33};
    localparam int PHASE_GAP   [N_PHASES] = '{0, 47, 21, 0, 47, 21};
    localparam int PHASE_ITEMS [N_PHASES] = '{250, 100, 250, 150, 100, 300};

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    t_cmd                i_cmd;
    logic                o_done;
    t_result             o_result;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    logic [KEY_W-1:0]    held_keys [MAX_ENTRIES];
    logic [CNT_W-1:0]    held_counts [MAX_ENTRIES];
    int                  held_used;
    logic [LIM_W-1:0]    held_limit;

    t_result             pending_results [$];
    t_cmd                row_cmd [$];
    bit                  row_typed [$];
    t_result             row_res [$];
    logic [KEY_W-1:0]    key_pool [POOL_N];

    bit                  send_typed;
    t_result             send_res;
    t_result             want;
    t_result             model_res;
    int                  cycles;
    int                  mismatches;
    int                  n_accepted;
    int                  n_checked;
    int                  n_limits;

    keyed_count_table dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        if (mismatches < 40) begin
            $display("mismatch at cycle %0d: %s is %0h, expected %0h", cycles, what, got,
                     exp_val);
        end
        mismatches++;
    endtask

    function automatic t_result tally_step(input t_cmd c);
        int               slot;
        int               eff;
        bit               found;
        logic [CNT_W:0]   sum;
        t_result          r;
        eff = (held_limit > MAX_ENTRIES) ? MAX_ENTRIES : int'(held_limit);
        slot = held_used;
        found = 1'b0;
        for (int i = 0; i < held_used; i++) begin
            if (!found && held_keys[i] == c.item_key) begin
                slot = i;
                found = 1'b1;
            end
        end
        r.accepted = 1'b0;
        r.item_count = found ? held_counts[slot] : '0;
        case (c.func)
            FUNC_ADD: begin
                if (c.amount != '0) begin
                    if (found) begin
                        sum = {1'b0, held_counts[slot]} + c.amount;
                        held_counts[slot] = sum[CNT_W] ? COUNT_MAX : sum[CNT_W-1:0];
                        r.item_count = held_counts[slot];
                        r.accepted = 1'b1;
                    end else if (held_used < eff) begin
                        held_keys[held_used] = c.item_key;
                        held_counts[held_used] = CNT_W'(c.amount);
                        r.item_count = CNT_W'(c.amount);
                        held_used++;
                        r.accepted = 1'b1;
                    end
                end
            end
            FUNC_REMOVE: begin
                if (c.amount != '0 && found) begin
                    if (held_counts[slot] <= c.amount) begin
                        for (int i = slot; i + 1 < held_used; i++) begin
                            held_keys[i] = held_keys[i+1];
                            held_counts[i] = held_counts[i+1];
                        end
                        held_used--;
                        r.item_count = '0;
                    end else begin
                        held_counts[slot] = held_counts[slot] - c.amount;
                        r.item_count = held_counts[slot];
                    end
                    r.accepted = 1'b1;
                end
            end
            FUNC_QUERY: begin
                r.accepted = found;
            end
            default: begin
                r.item_count = '0;
            end
        endcase
        r.used_entries = 6'(held_used);
        r.has_space = (held_used < eff);
        return r;
    endfunction

    function automatic t_cmd make_cmd();
        t_cmd c;
        int   pick;
        pick = $urandom_range(99);
        if (pick < 45) begin
            c.func = FUNC_ADD;
        end else if (pick < 72) begin
            c.func = FUNC_REMOVE;
        end else if (pick < 94) begin
            c.func = FUNC_QUERY;
        end else begin
            c.func = FUNC_NONE;
        end
        if ($urandom_range(19) == 0) begin
            c.item_key = $urandom;
        end else begin
            c.item_key = key_pool[$urandom_range(POOL_N-1)];
        end
        pick = $urandom_range(9);
        case (pick)
            0: c.amount = '0;
            1: c.amount = '1;
            2, 3, 4, 5: c.amount = AMT_W'($urandom_range(1, 16));
            default: c.amount = AMT_W'($urandom);
        endcase
        return c;
    endfunction

    // Called and left at a falling edge; returns once the command transfer has happened.
    task automatic send_cmd(input t_cmd c, input bit typed, input t_result res,
                            input int gap_pct);
        int gap;
        int seen;
        if ($urandom_range(99) < gap_pct) begin
            gap = ($urandom_range(7) == 0) ? $urandom_range(5, 150) : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start      <= 1'b1;
        i_cmd      <= c;
        send_typed <= typed;
        send_res   <= res;
        seen = n_accepted;
        do @(negedge i_clk); while (n_accepted == seen);
    endtask

    task automatic add_row(input logic [1:0] func, input logic [KEY_W-1:0] key,
                           input logic [AMT_W-1:0] amt, input bit typed, input logic acc,
                           input logic [CNT_W-1:0] cnt, input logic [5:0] used,
                           input logic space);
        t_cmd    c;
        t_result r;
        c.func = func;
        c.item_key = key;
        c.amount = amt;
        r.accepted = acc;
        r.item_count = cnt;
        r.used_entries = used;
        r.has_space = space;
        row_cmd.push_back(c);
        row_typed.push_back(typed);
        row_res.push_back(r);
    endtask

    task automatic walk_rows();
        foreach (row_cmd[i]) begin
            send_cmd(row_cmd[i], row_typed[i], row_res[i], 0);
        end
        row_cmd.delete();
        row_typed.delete();
        row_res.delete();
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0 || busy);
    endtask

    task automatic write_slot_limit(input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_SLOT_LIMIT;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        held_limit = value[LIM_W-1:0];
        n_limits++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== DATA_W'(held_limit)) begin
            report_mismatch("slot_limit read back", 64'(prdata), 64'(held_limit));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL keyed_count_table");
            $finish;
        end
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("result with none pending", 64'(o_result), '0);
                end else begin
                    want = pending_results.pop_front();
                    n_checked++;
                    if (o_result.accepted !== want.accepted)
                        report_mismatch("accepted", 64'(o_result.accepted),
                                        64'(want.accepted));
                    if (o_result.item_count !== want.item_count)
                        report_mismatch("item_count", 64'(o_result.item_count),
                                        64'(want.item_count));
                    if (o_result.used_entries !== want.used_entries)
                        report_mismatch("used_entries", 64'(o_result.used_entries),
                                        64'(want.used_entries));
                    if (o_result.has_space !== want.has_space)
                        report_mismatch("has_space", 64'(o_result.has_space),
                                        64'(want.has_space));
                end
            end
            if (start && busy === 1'b0) begin
                model_res = tally_step(i_cmd);
                pending_results.push_back(send_typed ? send_res : model_res);
                n_accepted <= n_accepted + 1;
            end
        end
    end

    initial begin
        t_result none;
        none = '0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_cmd      = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        send_typed = 1'b0;
        send_res   = '0;
        cycles     = 0;
        mismatches = 0;
        n_accepted = 0;
        n_checked  = 0;
        n_limits   = 0;
        held_used  = 0;
        held_limit = SLOT_LIMIT_RESET;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            held_keys[i] = '0;
            held_counts[i] = '0;
        end
        for (int i = 0; i < POOL_N; i++) begin
            key_pool[i] = $urandom;
        end
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        add_row(FUNC_QUERY,  32'h0000_0000, 16'h0000, 1, 0, 32'h0,       0, 1);
        add_row(FUNC_REMOVE, 32'h0000_0000, 16'h0005, 1, 0, 32'h0,       0, 1);
        add_row(FUNC_ADD,    32'hFFFF_FFFF, 16'h0000, 1, 0, 32'h0,       0, 1);
        add_row(FUNC_NONE,   32'h0000_0000, 16'hFFFF, 1, 0, 32'h0,       0, 1);
        add_row(FUNC_ADD,    32'hFFFF_FFFF, 16'hFFFF, 1, 1, 32'h0000FFFF, 1, 1);
        add_row(FUNC_ADD,    32'hFFFF_FFFF, 16'hFFFF, 1, 1, 32'h0001FFFE, 1, 1);
        add_row(FUNC_ADD,    32'h0000_0000, 16'h0001, 1, 1, 32'h1,       2, 1);
        add_row(FUNC_QUERY,  32'hFFFF_FFFF, 16'h0000, 1, 1, 32'h0001FFFE, 2, 1);
        add_row(FUNC_ADD,    32'hFFFF_FFFF, 16'h0000, 1, 0, 32'h0001FFFE, 2, 1);
        add_row(FUNC_REMOVE, 32'hFFFF_FFFF, 16'h0000, 1, 0, 32'h0001FFFE, 2, 1);
        add_row(FUNC_REMOVE, 32'h0000_0000, 16'hFFFF, 1, 1, 32'h0,       1, 1);
        add_row(FUNC_ADD,    32'h1234_5678, 16'h0007, 0, 1, 32'h7,       2, 1);
        add_row(FUNC_ADD,    32'hA5A5_A5A5, 16'h0003, 0, 1, 32'h3,       3, 1);
        add_row(FUNC_REMOVE, 32'hFFFF_FFFF, 16'h0001, 0, 1, 32'h0001FFFD, 3, 1);
        add_row(FUNC_REMOVE, 32'hFFFF_FFFF, 16'hFFFF, 1, 1, 32'h0000FFFE, 3, 1);
        add_row(FUNC_REMOVE, 32'hFFFF_FFFF, 16'hFFFE, 1, 1, 32'h0,       2, 1);
        add_row(FUNC_NONE,   32'h1234_5678, 16'h0001, 1, 0, 32'h0,       2, 1);
        add_row(FUNC_QUERY,  32'hA5A5_A5A5, 16'h0000, 0, 1, 32'h3,       2, 1);
        add_row(FUNC_REMOVE, 32'h1234_5678, 16'h0007, 1, 1, 32'h0,       1, 1);
        add_row(FUNC_QUERY,  32'h1234_5678, 16'h0000, 1, 0, 32'h0,       1, 1);
        add_row(FUNC_ADD,    32'hA5A5_A5A5, 16'hFFFF, 0, 1, 32'h00010002, 1, 1);
        add_row(FUNC_REMOVE, 32'hA5A5_A5A5, 16'hFFFF, 0, 1, 32'h3,       1, 1);
        walk_rows();

        drain();
        write_slot_limit(32'h0000_0000);
        add_row(FUNC_ADD,    32'hDEAD_BEEF, 16'h0001, 1, 0, 32'h0,       1, 0);
        add_row(FUNC_ADD,    32'hA5A5_A5A5, 16'h0001, 1, 1, 32'h4,       1, 0);
        add_row(FUNC_QUERY,  32'hDEAD_BEEF, 16'h0000, 1, 0, 32'h0,       1, 0);
        walk_rows();

        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            write_slot_limit({26'($urandom_range(0, 67108863)), 6'(PHASE_LIMIT[p])});
            for (int i = 0; i < 10; i++) begin
                key_pool[$urandom_range(POOL_N-1)] = $urandom;
            end
            for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
                send_cmd(make_cmd(), 1'b0, none, PHASE_GAP[p]);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        $display("Ran %0d commands with %0d results checked in %0d cycles.", n_accepted,
                 n_checked, cycles);
        $display("Slot limit was written %0d times, sender gaps in some phases.", n_limits);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("PASS keyed_count_table");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     pending_results.size());
            $display("FAIL keyed_count_table");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/kct_pkg.sv
rtl/core/kct_ram.sv
rtl/core/keyed_count_table.sv
verif/testbench.sv
